>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and gated by an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/b64e_pkg.sv
// ---------------------------------------------------------------------------
// Base64 encoder package
// Shared types, constants and the character mapping function for the stream encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_TWO   = 2'd2,
        FILL_BAD   = 2'd3
    } t_fill;

    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  pads;
        logic        final_grp;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] c;
        logic [7:0] wide;
        wide = {2'b00, idx};
        priority if (idx < 6'd26) begin
            c = 8'h41 + wide;
        end else if (idx < 6'd52) begin
            c = 8'h61 + wide - 8'd26;
        end else if (idx < 6'd62) begin
            c = 8'h30 + wide - 8'd52;
        end else if (idx == 6'd62) begin
            c = 8'h2b;
        end else begin
            c = 8'h2f;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/b64e_front.sv
// ---------------------------------------------------------------------------
// Base64 encoder front end
// Gathers bytes into groups of three and pushes each closed group to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_ready,
    input  b64e_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output b64e_pkg::t_group  o_group,
    output b64e_pkg::t_fill   o_fill
);

    b64e_pkg::t_fill r_fill, n_fill;
    logic [15:0]     r_held, n_held;
    logic            w_acc;

    assign o_ready = !i_q_stat.full;
    assign w_acc   = i_valid && o_ready;
    assign o_fill  = r_fill;

    always_comb begin
        n_fill  = r_fill;
        n_held  = r_held;
        o_push  = 1'b0;
        o_group = '0;
        unique case (r_fill)
            b64e_pkg::FILL_EMPTY: begin
                o_group.bytes = {i_byte, 16'h0000};
                o_group.pads  = 2'd2;
            end
            b64e_pkg::FILL_ONE: begin
                o_group.bytes = {r_held[15:8], i_byte, 8'h00};
                o_group.pads  = 2'd1;
            end
            default: begin
                o_group.bytes = {r_held, i_byte};
                o_group.pads  = 2'd0;
            end
        endcase
        o_group.final_grp = i_last;
        if (w_acc) begin
            if (i_last || r_fill == b64e_pkg::FILL_TWO || r_fill == b64e_pkg::FILL_BAD) begin
                o_push = 1'b1;
                n_fill = b64e_pkg::FILL_EMPTY;
                n_held = '0;
            end else if (r_fill == b64e_pkg::FILL_EMPTY) begin
                n_fill = b64e_pkg::FILL_ONE;
                n_held = {i_byte, 8'h00};
            end else begin
                n_fill = b64e_pkg::FILL_TWO;
                n_held = {r_held[15:8], i_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= b64e_pkg::FILL_EMPTY;
            r_held <= '0;
        end else begin
            r_fill <= n_fill;
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/core/b64e_queue.sv
// ---------------------------------------------------------------------------
// Base64 encoder group queue
// Short first-in first-out queue of closed groups between front and back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64e_pkg::t_group  i_group,
    input  logic              i_pop,
    output b64e_pkg::t_group  o_head,
    output b64e_pkg::t_q_stat o_stat
);

    b64e_pkg::t_group                 r_mem [b64e_pkg::FIFO_DEPTH];
    logic [b64e_pkg::PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [b64e_pkg::CNT_W-1:0]       r_count;
    logic                             w_wr, w_rd;

    assign o_stat.full  = (r_count == b64e_pkg::CNT_W'(b64e_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && !o_stat.full;
    assign w_rd         = i_pop && !o_stat.empty;

    function automatic logic [b64e_pkg::PTR_W-1:0] ptr_inc(
        input logic [b64e_pkg::PTR_W-1:0] p
    );
        logic [b64e_pkg::PTR_W-1:0] r;
        if (p == b64e_pkg::PTR_W'(b64e_pkg::FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/b64e_back.sv
// ---------------------------------------------------------------------------
// Base64 encoder back end
// Expands one queued group into four characters through a registered output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  b64e_pkg::t_group  i_head,
    input  b64e_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    output logic [7:0]        o_char,
    output logic              o_last,
    input  logic              i_ready
);

    b64e_pkg::t_group r_cur;
    logic [1:0]       r_pos;
    logic             r_busy;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;

    logic             w_adv;
    logic             w_done;
    logic [5:0]       w_idx;
    logic [2:0]       w_sum;
    logic [7:0]       w_char;

    assign w_adv  = !r_out_valid || i_ready;
    assign w_done = w_adv && r_busy && (r_pos == 2'd3);
    assign o_pop  = !i_q_stat.empty && (!r_busy || w_done);

    always_comb begin
        unique case (r_pos)
            2'd0:    w_idx = r_cur.bytes[23:18];
            2'd1:    w_idx = r_cur.bytes[17:12];
            2'd2:    w_idx = r_cur.bytes[11:6];
            default: w_idx = r_cur.bytes[5:0];
        endcase
        w_sum  = {1'b0, r_pos} + {1'b0, r_cur.pads};
        w_char = (w_sum > 3'd3) ? b64e_pkg::PAD_CHAR : b64e_pkg::enc_char(w_idx);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_out_char <= w_char;
            r_out_last <= r_cur.final_grp && (r_pos == 2'd3);
        end
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
                r_pos  <= '0;
            end else if (w_adv && r_busy) begin
                r_pos  <= r_pos + 1'b1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

>>> rtl/core/base64_stream_encoder.sv
// Path: with the back end idle, a closing byte's group passes the queue memory and the
// back end's current-group register before its first character reaches the output register;
// earlier groups or a stalled output delay it further.
// Throughput: one character per cycle at the output register while it is not stalled and groups
// are queued, four per group; bytes enter one per cycle while the two-entry group queue has room.
// Reset: synchronous, active low; clears the gathered bytes, queue and output valid.
// ---------------------------------------------------------------------------
// Base64 stream encoder
// Byte stream in, base64 character stream out, '=' padding on the final group.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast
);

    b64e_pkg::t_q_stat w_q_stat;
    b64e_pkg::t_group  w_group;
    b64e_pkg::t_group  w_head;
    b64e_pkg::t_fill   w_fill;
    logic              w_push;
    logic              w_pop;
    logic              w_final_push;

    assign w_final_push = w_push && w_group.final_grp;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_group  (w_group),
        .o_fill   (w_fill)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_group),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .o_char   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .i_ready  (m_axis_tready)
    );

    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_stat.full)
    `ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_q_stat.empty)
    `ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, w_final_push, w_fill == b64e_pkg::FILL_EMPTY)

endmodule
